@@ hw/rtl/suffix_automaton_matcher_macros.svh @@
// ----------------------------------------------------------------------------
// Suffix automaton matcher assertion macros
// Shorthand for clocked implication checks with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SUFFIX_AUTOMATON_MATCHER_MACROS_SVH
`define SUFFIX_AUTOMATON_MATCHER_MACROS_SVH

// same-cycle implication
`define SAM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sam assertion failed");

// next-cycle implication
`define SAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sam assertion failed");

`endif

@@ hw/rtl/sam_pkg.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton matcher package
// Shared field widths, item codes and transaction payload types.
// ----------------------------------------------------------------------------
package sam_pkg;

    localparam int LEN_W  = 11;
    localparam int KIND_W = 2;
    localparam int SYM_W  = 4;
    localparam int OUT_W  = 11;

    localparam logic [KIND_W-1:0] KIND_APPEND   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MATCH    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [LEN_W-1:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  symbol;
    } in_item_t;

    typedef struct packed {
        logic             status;
        logic [OUT_W-1:0] match_length;
        logic [OUT_W-1:0] match_state;
        logic             reached_cap;
        logic [OUT_W-1:0] states_used;
    } out_item_t;

endpackage

@@ hw/rtl/sam_ram.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton matcher RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module sam_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/suffix_automaton_matcher.sv @@
// Append: the suffix-link walk writes transitions until it runs off the root or meets
//   an existing transition, which may need a clone and redirects; match follows links
//   until a transition is found; restart and refused append go straight to the result.
// Throughput: one transaction at a time; the result waits while a prior one is unread.
// Reset: synchronous, active low; then a clearing pass over every address zeroes
//   both RAMs, during which s_ready stays low (configuration writes still taken).
// ----------------------------------------------------------------------------
// Suffix automaton matcher
// Online suffix automaton build over digits plus a streaming match cursor.
// ----------------------------------------------------------------------------
`include "suffix_automaton_matcher_macros.svh"

module suffix_automaton_matcher #(
    parameter int MAX_STATES = 2048,
    parameter int ALPHABET   = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sam_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sam_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [sam_pkg::LEN_W-1:0] cfg_data
);

    localparam int SW     = $clog2(MAX_STATES);
    localparam int LW     = sam_pkg::LEN_W;
    localparam int ROW_W  = ALPHABET * SW;
    localparam int NODE_W = SW + LW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_A_LEN, ST_A_WALK, ST_A_Y, ST_A_CLONE, ST_A_RED,
        ST_M_WALK, ST_FINISH
    } fsm_t;

    fsm_t fsm_reg, fsm_next;

    logic [sam_pkg::SYM_W-1:0] sym_reg, sym_next;
    logic [SW-1:0] count_reg, count_next;
    logic [SW-1:0] last_reg, last_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [LW-1:0] curlen_reg, curlen_next;
    logic [LW-1:0] cap_reg, cap_next;
    logic [SW-1:0] x_reg, x_next;
    logic [SW-1:0] fresh_reg, fresh_next;
    logic [SW-1:0] y_reg, y_next;
    logic [SW-1:0] twin_reg, twin_next;
    logic [LW-1:0] flen_reg, flen_next;
    logic [LW:0]   xlen1_reg, xlen1_next;
    logic [LW-1:0] ylen_reg, ylen_next;
    logic [LW-1:0] mlen_reg, mlen_next;
    logic          follow_reg, follow_next;
    logic          status_reg, status_next;
    logic [SW-1:0] clr_reg, clr_next;
    logic [SW-1:0] tr_raddr_reg, tr_raddr_next;
    logic [SW-1:0] nd_raddr_reg, nd_raddr_next;
    logic          m_valid_reg, m_valid_next;
    sam_pkg::out_item_t out_reg, out_next;

    logic              tr_we, nd_we;
    logic [SW-1:0]     tr_waddr, nd_waddr;
    logic [ROW_W-1:0]  tr_wdata, tr_rdata;
    logic [NODE_W-1:0] nd_wdata, nd_rdata;

    logic [SW-1:0] entry;
    logic [SW-1:0] nd_link;
    logic [LW-1:0] nd_len;
    logic [LW-1:0] leff;
    logic [LW:0]   nl;
    logic [LW-1:0] shown;
    logic          s_accept;
    logic          sym_ok;

    sam_ram #(.DATA_W(ROW_W), .DEPTH(MAX_STATES)) u_trans (
        .aclk  (aclk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .raddr (tr_raddr_next),
        .rdata (tr_rdata)
    );

    sam_ram #(.DATA_W(NODE_W), .DEPTH(MAX_STATES)) u_node (
        .aclk  (aclk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .raddr (nd_raddr_next),
        .rdata (nd_rdata)
    );

    assign s_ready   = (fsm_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign entry   = tr_rdata[int'(sym_reg) * SW +: SW];
    assign nd_link = nd_rdata[NODE_W-1 -: SW];
    assign nd_len  = nd_rdata[LW-1:0];
    assign leff    = follow_reg ? nd_len : mlen_reg;
    assign nl      = {1'b0, leff} + (LW+1)'(1);
    assign shown   = (curlen_reg < cap_reg) ? curlen_reg : cap_reg;
    assign sym_ok  = (32'(s_data.symbol) < ALPHABET);

    always_comb begin
        fsm_next      = fsm_reg;
        sym_next      = sym_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        cur_next      = cur_reg;
        curlen_next   = curlen_reg;
        cap_next      = cap_reg;
        x_next        = x_reg;
        fresh_next    = fresh_reg;
        y_next        = y_reg;
        twin_next     = twin_reg;
        flen_next     = flen_reg;
        xlen1_next    = xlen1_reg;
        ylen_next     = ylen_reg;
        mlen_next     = mlen_reg;
        follow_next   = follow_reg;
        status_next   = status_reg;
        clr_next      = clr_reg;
        tr_raddr_next = tr_raddr_reg;
        nd_raddr_next = nd_raddr_reg;
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;
        tr_we         = 1'b0;
        tr_waddr      = x_reg;
        tr_wdata      = tr_rdata;
        nd_we         = 1'b0;
        nd_waddr      = fresh_reg;
        nd_wdata      = {SW'(1), flen_reg};

        if (cfg_valid && cfg_ready) begin
            cap_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (fsm_reg)
            ST_CLEAR: begin
                tr_we    = 1'b1;
                tr_waddr = clr_reg;
                tr_wdata = '0;
                nd_we    = 1'b1;
                nd_waddr = clr_reg;
                nd_wdata = '0;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(MAX_STATES - 1)) begin
                    fsm_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    sym_next    = s_data.symbol;
                    status_next = sam_pkg::STATUS_DONE;
                    fsm_next    = ST_FINISH;
                    case (s_data.kind)
                        sam_pkg::KIND_APPEND: begin
                            if (!sym_ok) begin
                                fsm_next = ST_FINISH;
                            end else if ((32'(count_reg) + 2) > (MAX_STATES - 1)) begin
                                status_next = sam_pkg::STATUS_FULL;
                            end else begin
                                x_next        = last_reg;
                                fresh_next    = count_reg + SW'(1);
                                count_next    = count_reg + SW'(1);
                                tr_raddr_next = last_reg;
                                nd_raddr_next = last_reg;
                                fsm_next      = ST_A_LEN;
                            end
                        end
                        sam_pkg::KIND_MATCH: begin
                            if (!sym_ok) begin
                                cur_next    = SW'(1);
                                curlen_next = '0;
                            end else begin
                                x_next        = cur_reg;
                                mlen_next     = curlen_reg;
                                follow_next   = 1'b0;
                                tr_raddr_next = cur_reg;
                                nd_raddr_next = cur_reg;
                                fsm_next      = ST_M_WALK;
                            end
                        end
                        sam_pkg::KIND_RESTART: begin
                            cur_next    = SW'(1);
                            curlen_next = '0;
                        end
                        default: begin
                            fsm_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_A_LEN: begin
                flen_next = nd_len + LW'(1);
                fsm_next  = ST_A_WALK;
            end
            ST_A_WALK: begin
                if (x_reg == '0) begin
                    nd_we     = 1'b1;
                    nd_waddr  = fresh_reg;
                    nd_wdata  = {SW'(1), flen_reg};
                    last_next = fresh_reg;
                    fsm_next  = ST_FINISH;
                end else if (entry == '0) begin
                    tr_we    = 1'b1;
                    tr_waddr = x_reg;
                    tr_wdata[int'(sym_reg) * SW +: SW] = fresh_reg;
                    x_next        = nd_link;
                    tr_raddr_next = nd_link;
                    nd_raddr_next = nd_link;
                end else begin
                    y_next        = entry;
                    xlen1_next    = {1'b0, nd_len} + (LW+1)'(1);
                    nd_raddr_next = entry;
                    fsm_next      = ST_A_Y;
                end
            end
            ST_A_Y: begin
                ylen_next = nd_len;
                if ({1'b0, nd_len} == xlen1_reg) begin
                    nd_we     = 1'b1;
                    nd_waddr  = fresh_reg;
                    nd_wdata  = {y_reg, flen_reg};
                    last_next = fresh_reg;
                    fsm_next  = ST_FINISH;
                end else begin
                    twin_next     = count_reg + SW'(1);
                    count_next    = count_reg + SW'(1);
                    nd_we         = 1'b1;
                    nd_waddr      = count_reg + SW'(1);
                    nd_wdata      = {nd_link, xlen1_reg[LW-1:0]};
                    tr_raddr_next = y_reg;
                    fsm_next      = ST_A_CLONE;
                end
            end
            ST_A_CLONE: begin
                // y now links to the clone; clone takes y's whole row
                nd_we         = 1'b1;
                nd_waddr      = y_reg;
                nd_wdata      = {twin_reg, ylen_reg};
                tr_we         = 1'b1;
                tr_waddr      = twin_reg;
                tr_wdata      = tr_rdata;
                tr_raddr_next = x_reg;
                nd_raddr_next = x_reg;
                fsm_next      = ST_A_RED;
            end
            ST_A_RED: begin
                if (x_reg != '0 && entry == y_reg) begin
                    tr_we    = 1'b1;
                    tr_waddr = x_reg;
                    tr_wdata[int'(sym_reg) * SW +: SW] = twin_reg;
                    x_next        = nd_link;
                    tr_raddr_next = nd_link;
                    nd_raddr_next = nd_link;
                end else begin
                    nd_we     = 1'b1;
                    nd_waddr  = fresh_reg;
                    nd_wdata  = {twin_reg, flen_reg};
                    last_next = fresh_reg;
                    fsm_next  = ST_FINISH;
                end
            end
            ST_M_WALK: begin
                if (x_reg != '0 && entry != '0) begin
                    cur_next    = entry;
                    curlen_next = (nl > {1'b0, cap_reg}) ? cap_reg : nl[LW-1:0];
                    fsm_next    = ST_FINISH;
                end else if (x_reg == '0) begin
                    cur_next    = SW'(1);
                    curlen_next = '0;
                    fsm_next    = ST_FINISH;
                end else begin
                    x_next        = nd_link;
                    follow_next   = 1'b1;
                    tr_raddr_next = nd_link;
                    nd_raddr_next = nd_link;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    out_next.status       = status_reg;
                    out_next.match_length = sam_pkg::OUT_W'(shown);
                    out_next.match_state  = sam_pkg::OUT_W'(cur_reg);
                    out_next.reached_cap  = (shown == cap_reg);
                    out_next.states_used  = sam_pkg::OUT_W'(count_reg);
                    fsm_next              = ST_IDLE;
                end
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= ST_CLEAR;
            clr_reg      <= '0;
            count_reg    <= SW'(1);
            last_reg     <= SW'(1);
            cur_reg      <= SW'(1);
            curlen_reg   <= '0;
            cap_reg      <= sam_pkg::CAP_RESET;
            m_valid_reg  <= 1'b0;
            tr_raddr_reg <= '0;
            nd_raddr_reg <= '0;
        end else begin
            fsm_reg      <= fsm_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            cur_reg      <= cur_next;
            curlen_reg   <= curlen_next;
            cap_reg      <= cap_next;
            m_valid_reg  <= m_valid_next;
            tr_raddr_reg <= tr_raddr_next;
            nd_raddr_reg <= nd_raddr_next;
        end
        sym_reg    <= sym_next;
        x_reg      <= x_next;
        fresh_reg  <= fresh_next;
        y_reg      <= y_next;
        twin_reg   <= twin_next;
        flen_reg   <= flen_next;
        xlen1_reg  <= xlen1_next;
        ylen_reg   <= ylen_next;
        mlen_reg   <= mlen_next;
        follow_reg <= follow_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    `SAM_ASSERT_IMPL(a_clear_blocks_input, aclk, aresetn, fsm_reg == ST_CLEAR, !s_ready)
    `SAM_ASSERT_NEXT(a_result_from_finish, aclk, aresetn,
        !m_valid_reg && fsm_reg != ST_FINISH, !m_valid_reg)
    `SAM_ASSERT_NEXT(a_count_idle_stable, aclk, aresetn,
        fsm_reg == ST_IDLE && !s_accept, $stable(count_reg))

endmodule
